/* design/pat_pkg.sv */
package pat_pkg;

	// Register file geometry. Words at or beyond REG_WORDS lie outside the block.
	localparam int unsigned REG_WORDS   = 32;
	localparam int unsigned MAP_WORDS   = 28;
	localparam int unsigned STORE_WORDS = (REG_WORDS < MAP_WORDS) ? REG_WORDS : MAP_WORDS;

	localparam logic [8:0] REG_WORDS_LIM = 9'(REG_WORDS);

	// Actions carried by an input item.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// Byte offsets of the registers with side effects.
	localparam logic [9:0] OFS_CR1 = 10'h000;
	localparam logic [9:0] OFS_SR  = 10'h010;
	localparam logic [9:0] OFS_EGR = 10'h014;
	localparam logic [9:0] OFS_CNT = 10'h024;
	localparam logic [9:0] OFS_PSC = 10'h028;
	localparam logic [9:0] OFS_ARR = 10'h02C;

	// Matching word indexes.
	localparam int unsigned CR1_W = 0;
	localparam int unsigned SR_W  = 4;
	localparam int unsigned EGR_W = 5;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned PSC_W = 10;
	localparam int unsigned ARR_W = 11;

	localparam int unsigned CEN_BIT = 0;
	localparam int unsigned OPM_BIT = 3;
	localparam int unsigned UIF_BIT = 0;
	localparam int unsigned UG_BIT  = 0;

	localparam logic [31:0] WMASK [MAP_WORDS] = '{
		32'h00000BFF, 32'h00F57FFD, 32'h0031FFFF, 32'h00007FFF,
		32'h00033FFF, 32'h000001FF, 32'h0101FFFF, 32'h0101FFFF,
		32'h0033FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
		32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
		32'h0000FFFF, 32'h03FFFFFF, 32'h00001F1F, 32'hFFFFFFFF,
		32'h00000000, 32'h0101FCFC, 32'hE000FFFF, 32'h0000FFFF,
		32'h0003CF07, 32'h00000F07, 32'h00000000, 32'h0F0F0F0F
	};

	localparam logic [31:0] RSTVAL [MAP_WORDS] = '{
		32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
		32'h0, 32'h0, 32'h0, 32'h0000FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
		32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
		32'h00000001, 32'h00000001, 32'h0, 32'h0
	};

	typedef struct packed {
		logic [1:0]  action;
		logic [9:0]  ofs;
		logic [31:0] data;
	} pat_cmd_t;

	typedef struct packed {
		logic        step;
		logic        tick_en;
		logic        restart;
		logic [15:0] psc;
		logic [15:0] arr;
	} pat_cnt_ctl_t;

	typedef struct packed {
		logic        wrap;
		logic [15:0] live;
	} pat_cnt_stat_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        uif;
		logic        cen;
	} pat_rsp_t;

endpackage

/* design/pat_req_if.sv */
interface pat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  byte_offset;
	logic [31:0] write_data;

	modport source (output valid, output action, output byte_offset, output write_data,
		input ready);
	modport sink (input valid, input action, input byte_offset, input write_data,
		output ready);
endinterface

/* design/pat_rsp_if.sv */
interface pat_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        update_flag;
	logic        counting;

	modport source (output valid, output read_data, output update_flag, output counting,
		input ready);
	modport sink (input valid, input read_data, input update_flag, input counting,
		output ready);
endinterface

/* design/pat_counter.sv */
module pat_counter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pat_pkg::pat_cnt_ctl_t  ctl,
	output pat_pkg::pat_cnt_stat_t stat
);

	logic [15:0] pc_q;
	logic [15:0] lc_q;
	logic        pc_done;
	logic        lc_done;

	assign pc_done = (pc_q >= ctl.psc);
	assign lc_done = (lc_q >= ctl.arr);

	assign stat.wrap = ctl.tick_en && pc_done && lc_done;
	assign stat.live = lc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 16'd0;
			lc_q <= 16'd0;
		end else if (ctl.step) begin
			if (ctl.restart) begin
				pc_q <= 16'd0;
				lc_q <= 16'd0;
			end else if (ctl.tick_en) begin
				if (!pc_done) begin
					pc_q <= pc_q + 16'd1;
				end else begin
					pc_q <= 16'd0;
					lc_q <= lc_done ? 16'd0 : lc_q + 16'd1;
				end
			end
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && ctl.restart |=> pc_q == 16'd0 && lc_q == 16'd0)
		else $error("count not cleared after restart");

endmodule

/* design/pat_regfile.sv */
module pat_regfile (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  pat_pkg::pat_cmd_t      cmd,
	input  pat_pkg::pat_cnt_stat_t stat,
	output pat_pkg::pat_cnt_ctl_t  ctl,
	output pat_pkg::pat_rsp_t      rsp
);

	logic [pat_pkg::STORE_WORDS-1:0][31:0] word_q;
	logic [pat_pkg::STORE_WORDS-1:0][31:0] nxt_word;

	logic [7:0]  w;
	logic        aligned;
	logic        in_blk;
	logic        is_rd;
	logic        is_wr;
	logic        cen;
	logic        opm;
	logic [15:0] arr;
	logic [15:0] cap;
	logic        cnt_live_rd;
	logic        ug;
	logic        cen_rise;
	logic        set_uif;
	logic [31:0] rd_word;

	assign w       = cmd.ofs[9:2];
	assign aligned = (cmd.ofs[1:0] == 2'd0);
	assign in_blk  = ({1'b0, w} < pat_pkg::REG_WORDS_LIM);
	assign is_rd   = (cmd.action == pat_pkg::ACT_READ);
	assign is_wr   = (cmd.action == pat_pkg::ACT_WRITE);

	assign cen = word_q[pat_pkg::CR1_W][pat_pkg::CEN_BIT];
	assign opm = word_q[pat_pkg::CR1_W][pat_pkg::OPM_BIT];
	assign arr = word_q[pat_pkg::ARR_W][15:0];

	assign cap         = (stat.live > arr) ? arr : stat.live;
	assign cnt_live_rd = is_rd && (cmd.ofs == pat_pkg::OFS_CNT) && cen;

	assign ug       = is_wr && (cmd.ofs == pat_pkg::OFS_EGR) && cmd.data[pat_pkg::UG_BIT];
	assign cen_rise = is_wr && (cmd.ofs == pat_pkg::OFS_CR1) && cmd.data[pat_pkg::CEN_BIT]
		&& !cen;
	assign set_uif  = ug || stat.wrap;

	assign ctl.step    = step;
	assign ctl.tick_en = (cmd.action == pat_pkg::ACT_TICK) && cen;
	assign ctl.restart = ug || cen_rise;
	assign ctl.psc     = word_q[pat_pkg::PSC_W][15:0];
	assign ctl.arr     = arr;

	// Unaligned offsets read the word that holds them; unstored words read as zero.
	always_comb begin
		rd_word = 32'd0;
		for (int i = 0; i < pat_pkg::STORE_WORDS; i++) begin
			if (w == 8'(i)) begin
				rd_word = word_q[i];
			end
		end
	end

	always_comb begin
		if (!is_rd || !in_blk) begin
			rsp.read_data = 32'd0;
		end else if (cnt_live_rd) begin
			rsp.read_data = {16'd0, cap};
		end else begin
			rsp.read_data = rd_word;
		end
	end

	always_comb begin
		for (int i = 0; i < pat_pkg::STORE_WORDS; i++) begin
			nxt_word[i] = word_q[i];
			if (is_wr && aligned && (w == 8'(i))) begin
				nxt_word[i] = (word_q[i] & ~pat_pkg::WMASK[i])
					| (cmd.data & pat_pkg::WMASK[i]);
			end
			if (i == pat_pkg::EGR_W) begin
				nxt_word[i] = 32'd0;
			end
			if ((i == pat_pkg::SR_W) && set_uif) begin
				nxt_word[i][pat_pkg::UIF_BIT] = 1'b1;
			end
			if ((i == pat_pkg::CR1_W) && stat.wrap && opm) begin
				nxt_word[i][pat_pkg::CEN_BIT] = 1'b0;
			end
			if ((i == pat_pkg::CNT_W) && cnt_live_rd) begin
				nxt_word[i] = {16'd0, cap};
			end
		end
	end

	// Status and enable are reported as they stand after the transfer.
	assign rsp.uif = nxt_word[pat_pkg::SR_W][pat_pkg::UIF_BIT];
	assign rsp.cen = nxt_word[pat_pkg::CR1_W][pat_pkg::CEN_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pat_pkg::STORE_WORDS; i++) begin
				word_q[i] <= pat_pkg::RSTVAL[i];
			end
		end else if (step) begin
			word_q <= nxt_word;
		end
	end

	a_egr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		word_q[pat_pkg::EGR_W] == 32'd0)
		else $error("EGR holds a non-zero value");

	a_cnt_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_live_rd |-> rsp.read_data <= {16'd0, arr})
		else $error("live count read above ARR");

endmodule

/* design/prescaled_autoreload_timer.sv */
// Path: an input transfer is held in the input register, then moves to the result register
// when that register is empty or being read out; all actions take this path.
// Throughput: one item per cycle while results are taken; otherwise the item waits in stage one.
// Reset (arst_n low, asynchronous): registers take their reset values, ARR 0xFFFF,
// the prescaler and the count clear, and both pipeline stages empty.
module prescaled_autoreload_timer (
	input  logic      clk,
	input  logic      arst_n,
	pat_req_if.sink   req,
	pat_rsp_if.source rsp
);

	logic                   valid_s1;
	pat_pkg::pat_cmd_t      cmd_s1;
	logic                   out_valid_q;
	pat_pkg::pat_rsp_t      out_q;
	logic                   step;
	pat_pkg::pat_cnt_ctl_t  cnt_ctl;
	pat_pkg::pat_cnt_stat_t cnt_stat;
	pat_pkg::pat_rsp_t      nxt_rsp;

	assign step      = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1.action <= req.action;
			cmd_s1.ofs    <= req.byte_offset;
			cmd_s1.data   <= req.write_data;
		end
	end

	pat_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.stat   (cnt_stat),
		.ctl    (cnt_ctl),
		.rsp    (nxt_rsp)
	);

	pat_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cnt_ctl),
		.stat   (cnt_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= nxt_rsp;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = out_q.read_data;
	assign rsp.update_flag = out_q.uif;
	assign rsp.counting    = out_q.cen;

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("empty input stage refuses a transfer");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(cmd_s1))
		else $error("stalled item lost from the input stage");

endmodule
